### design/klq_pkg.sv
package klq_pkg;

   // Round count of the cipher; the cell chain has one cell per round.
   localparam int ROUND_COUNT = 528;

   localparam int BLOCK_WIDTH = 32;
   localparam int KEY_WIDTH   = 64;
   localparam int KEY_IDX_W   = $clog2(KEY_WIDTH);

   // Nonlinear function, indexed by five register bits.
   localparam logic [31:0] NLF_TABLE = 32'h3A5C_742E;

   // Operation codes carried on req_tuser.
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // One slot of the round chain.
   typedef struct packed {
      logic                   valid;
      logic                   op;
      logic [BLOCK_WIDTH-1:0] block;
   } stage_type;

   function automatic logic nlf(input logic [4:0] idx);
      return NLF_TABLE[idx];
   endfunction

   // Encryption round: shift right, new bit 31.
   function automatic logic [BLOCK_WIDTH-1:0] round_enc(input logic [BLOCK_WIDTH-1:0] x,
                                                       input logic                   k);
      logic fb;
      fb = x[0] ^ x[16] ^ k ^ nlf({x[31], x[26], x[20], x[9], x[1]});
      return {fb, x[31:1]};
   endfunction

   // Decryption round: shift left, new bit 0.
   function automatic logic [BLOCK_WIDTH-1:0] round_dec(input logic [BLOCK_WIDTH-1:0] x,
                                                       input logic                   k);
      logic fb;
      fb = x[31] ^ x[15] ^ k ^ nlf({x[30], x[25], x[19], x[8], x[0]});
      return {x[30:0], fb};
   endfunction

endpackage

### design/keeloq_cipher_core.sv
// KeeLoq block cipher core. Each request transaction carries one 32-bit block
// on req_tdata and the operation on req_tuser (0 encrypt, 1 decrypt); each
// produces exactly one response transaction with the transformed block on
// rsp_tdata, in request order. The 528 rounds are a chain of 528 round cells,
// one round per cell, so a new block can enter every cycle while the chain
// advances: sustained throughput is one transaction per clock when the
// output is not stalled. The chain advances as a whole whenever the output
// slot is empty or being taken; while it is held, one more request is parked
// in a skid register, so req_tready is a register output. The 64-bit key is
// written through the APB port at byte address 0 and must only change while
// no transaction is in flight; every cell reads one fixed key bit per op.
module keeloq_cipher_core (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] data_block
   input  logic [0:0]  req_tuser,    // [0] op
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] result_block
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int N = klq_pkg::ROUND_COUNT;

   logic [klq_pkg::KEY_WIDTH-1:0] cipher_key;
   klq_pkg::stage_type            stage [0:N];
   klq_pkg::stage_type            head_stage;
   logic                          chain_en;
   logic                          req_accept;

   // skid slot
   logic                            skid_full_ff;
   logic                            skid_full_in;
   logic                            skid_op_ff;
   logic [klq_pkg::BLOCK_WIDTH-1:0] skid_block_ff;

   klq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cipher_key  (cipher_key)
   );

   // Chain moves when the output slot is free or is being consumed.
   assign chain_en   = !rsp_tvalid || rsp_tready;
   assign req_tready = !skid_full_ff;
   assign req_accept = req_tvalid && req_tready;

   // Head of the chain: the parked transaction has priority (no new request
   // is accepted while the skid is full).
   always_comb begin
      if (skid_full_ff) begin
         head_stage.valid = 1'b1;
         head_stage.op    = skid_op_ff;
         head_stage.block = skid_block_ff;
      end else begin
         head_stage.valid = req_accept;
         head_stage.op    = req_tuser[0];
         head_stage.block = req_tdata;
      end
   end

   assign stage[0] = head_stage;

   always_comb begin
      skid_full_in = skid_full_ff;
      if (chain_en) begin
         skid_full_in = 1'b0;
      end else if (req_accept) begin
         skid_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else begin
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && !chain_en) begin
         skid_op_ff    <= req_tuser[0];
         skid_block_ff <= req_tdata;
      end
   end

   // Round cells. Cell r uses key bit r mod 64 for encryption and
   // (15 - r) mod 64 for decryption.
   for (genvar r = 0; r < N; r++) begin : g_round
      localparam int KE = r % klq_pkg::KEY_WIDTH;
      localparam int KD = (15 - r) & (klq_pkg::KEY_WIDTH - 1);

      klq_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (chain_en),
         .stage_in  (stage[r]),
         .key_enc   (cipher_key[KE[klq_pkg::KEY_IDX_W-1:0]]),
         .key_dec   (cipher_key[KD[klq_pkg::KEY_IDX_W-1:0]]),
         .stage_out (stage[r+1])
      );
   end

   assign rsp_tvalid = stage[N].valid;
   assign rsp_tdata  = stage[N].block;

   // A request taken while the chain is held must land in the skid slot.
   a_skid_capture: assert property (@(posedge clock) disable iff (reset)
      req_accept && !chain_en |=> skid_full_ff)
      else $error("stalled request not parked in skid");

   // A parked transaction enters the first cell as soon as the chain moves.
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && chain_en |=> stage[1].valid && !skid_full_ff)
      else $error("skid transaction lost on chain advance");

   // Reset leaves no response pending and the skid empty.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !skid_full_ff)
      else $error("state not cleared by reset");

endmodule

### design/klq_round_cell.sv
// One cipher round with its stage register.
module klq_round_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  klq_pkg::stage_type  stage_in,
   input  logic                key_enc,
   input  logic                key_dec,
   output klq_pkg::stage_type  stage_out
);

   logic                            valid_ff;
   logic                            valid_in;
   logic                            op_ff;
   logic [klq_pkg::BLOCK_WIDTH-1:0] block_ff;
   logic [klq_pkg::BLOCK_WIDTH-1:0] block_in;

   assign valid_in = stage_in.valid;

   always_comb begin
      if (stage_in.op == klq_pkg::OP_DECRYPT) begin
         block_in = klq_pkg::round_dec(stage_in.block, key_dec);
      end else begin
         block_in = klq_pkg::round_enc(stage_in.block, key_enc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         op_ff    <= stage_in.op;
         block_ff <= block_in;
      end
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.op    = op_ff;
   assign stage_out.block = block_ff;

endmodule

### design/klq_csr.sv
// APB register file: cipher_key at byte address 0.
module klq_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [3:0]                    csr_paddr,
   input  logic [klq_pkg::KEY_WIDTH-1:0] csr_pwdata,
   output logic [klq_pkg::KEY_WIDTH-1:0] csr_prdata,
   output logic                          csr_pready,
   output logic [klq_pkg::KEY_WIDTH-1:0] cipher_key
);

   localparam logic REG_CIPHER_KEY = 1'b0;

   logic [klq_pkg::KEY_WIDTH-1:0] key_ff;
   logic [klq_pkg::KEY_WIDTH-1:0] key_in;
   logic                          key_we;

   assign csr_pready = 1'b1;
   // register index is paddr[3] (8-byte spacing)
   assign key_we = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[3] == REG_CIPHER_KEY);
   assign key_in = key_we ? csr_pwdata : key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         REG_CIPHER_KEY: csr_prdata = key_ff;
         default:        csr_prdata = '0;
      endcase
   end

   assign cipher_key = key_ff;

endmodule
